// ===== design/rcpcf_pkg.sv =====
package rcpcf_pkg;

  localparam int NUM_CH    = 8;
  localparam int CH_W      = 3;
  localparam int VAL_W     = 16;
  localparam int TIME_W    = 32;
  localparam int NUM_FS_CH = 4;
  localparam int CFG_IDX_W = 2;

  localparam logic OP_EDGE   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FS_VALUE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FS_ENABLE = 2'd2;

  localparam logic [VAL_W-1:0] RESET_TIMEOUT  = 16'd500;
  localparam logic [VAL_W-1:0] RESET_FS_VALUE = 16'd1500;

  typedef logic [NUM_CH-1:0][VAL_W-1:0] chan_arr_t;

  typedef struct packed {
    logic              op;
    logic [CH_W-1:0]   ch;
    logic              level;
    logic [TIME_W-1:0] now_us;
    logic [TIME_W-1:0] now_ms;
  } item_t;

  typedef struct packed {
    logic [VAL_W-1:0] timeout;
    logic [VAL_W-1:0] fs_value;
    logic             fs_enable;
  } cfg_t;

endpackage

// ===== design/rc_pulse_capture_filter_unit.sv =====
// a loop-sample beat is held in the input register once accepted, and its result is then
// registered into the value registers together with the output valid flag
// throughput: one beat per cycle; a loop sample waits only while the previous
// result is still held at the output
// reset: config registers take their defaults, all capture and filter state
// is zero; ring rows carry valid bits, so no clearing pass is needed
module rc_pulse_capture_filter_unit #(
  parameter int FILTER_DEPTH = 4
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            operation_i,
  input  logic [rcpcf_pkg::CH_W-1:0]      channel_i,
  input  logic                            pin_level_i,
  input  logic [rcpcf_pkg::TIME_W-1:0]    now_us_i,
  input  logic [rcpcf_pkg::TIME_W-1:0]    now_ms_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [rcpcf_pkg::VAL_W-1:0]     roll_value_o,
  output logic [rcpcf_pkg::VAL_W-1:0]     pitch_value_o,
  output logic [rcpcf_pkg::VAL_W-1:0]     throttle_value_o,
  output logic [rcpcf_pkg::VAL_W-1:0]     yaw_value_o,
  output logic [rcpcf_pkg::VAL_W-1:0]     aux1_value_o,
  output logic [rcpcf_pkg::VAL_W-1:0]     aux2_value_o,
  output logic [rcpcf_pkg::VAL_W-1:0]     aux3_value_o,
  output logic [rcpcf_pkg::VAL_W-1:0]     aux4_value_o,
  output logic                            failsafe_active_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [rcpcf_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [rcpcf_pkg::VAL_W-1:0]     cfg_data_i
);

  rcpcf_pkg::cfg_t              cfg_q, cfg_d;
  rcpcf_pkg::item_t             s1_item_q;
  logic                         s1_valid_q, s1_valid_d;
  logic                         out_valid_q, out_valid_d;
  logic                         s1_adv;
  logic                         edge_fire;
  logic                         sample_fire;
  rcpcf_pkg::chan_arr_t         widths;
  rcpcf_pkg::chan_arr_t         values;
  logic [rcpcf_pkg::TIME_W-1:0] last_act;
  logic                         active;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        rcpcf_pkg::CFG_TIMEOUT:   cfg_d.timeout   = cfg_data_i;
        rcpcf_pkg::CFG_FS_VALUE:  cfg_d.fs_value  = cfg_data_i;
        rcpcf_pkg::CFG_FS_ENABLE: cfg_d.fs_enable = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // edge beats never touch the output, so they always move on
  assign s1_adv = s1_valid_q &&
                  (s1_item_q.op == rcpcf_pkg::OP_EDGE || !out_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || s1_adv;
  assign edge_fire   = s1_adv && (s1_item_q.op == rcpcf_pkg::OP_EDGE);
  assign sample_fire = s1_adv && (s1_item_q.op == rcpcf_pkg::OP_SAMPLE);

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_ready_o) begin
      s1_valid_d = in_valid_i;
    end
    out_valid_d = out_valid_q;
    if (sample_fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timeout   <= rcpcf_pkg::RESET_TIMEOUT;
      cfg_q.fs_value  <= rcpcf_pkg::RESET_FS_VALUE;
      cfg_q.fs_enable <= 1'b1;
      s1_valid_q      <= 1'b0;
      out_valid_q     <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_item_q.op     <= operation_i;
      s1_item_q.ch     <= channel_i;
      s1_item_q.level  <= pin_level_i;
      s1_item_q.now_us <= now_us_i;
      s1_item_q.now_ms <= now_ms_i;
    end
  end

  rcpcf_capture u_capture (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (edge_fire),
    .item_i     (s1_item_q),
    .widths_o   (widths),
    .last_act_o (last_act)
  );

  rcpcf_filter #(
    .FILTER_DEPTH (FILTER_DEPTH)
  ) u_filter (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (sample_fire),
    .now_ms_i   (s1_item_q.now_ms),
    .cfg_i      (cfg_q),
    .widths_i   (widths),
    .last_act_i (last_act),
    .values_o   (values),
    .active_o   (active)
  );

  // channel value registers hold still while a result beat is pending
  assign out_valid_o       = out_valid_q;
  assign roll_value_o      = values[0];
  assign pitch_value_o     = values[1];
  assign throttle_value_o  = values[2];
  assign yaw_value_o       = values[3];
  assign aux1_value_o      = values[4];
  assign aux2_value_o      = values[5];
  assign aux3_value_o      = values[6];
  assign aux4_value_o      = values[7];
  assign failsafe_active_o = active;

endmodule

// ===== design/rcpcf_ram.sv =====
module rcpcf_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 4
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/rcpcf_capture.sv =====
module rcpcf_capture (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                fire_i,
  input  rcpcf_pkg::item_t                    item_i,
  output rcpcf_pkg::chan_arr_t                widths_o,
  output logic [rcpcf_pkg::TIME_W-1:0]        last_act_o
);

  rcpcf_pkg::chan_arr_t                start_q, start_d;
  rcpcf_pkg::chan_arr_t                width_q, width_d;
  logic [rcpcf_pkg::TIME_W-1:0]        last_act_q, last_act_d;
  logic [rcpcf_pkg::VAL_W-1:0]         now_lo;

  assign now_lo = item_i.now_us[rcpcf_pkg::VAL_W-1:0];

  always_comb begin
    start_d    = start_q;
    width_d    = width_q;
    last_act_d = last_act_q;
    if (fire_i) begin
      // only roll and pitch count as link activity
      if (item_i.ch < rcpcf_pkg::CH_W'(2)) begin
        last_act_d = item_i.now_ms;
      end
      if (item_i.level) begin
        start_d[item_i.ch] = now_lo;
      end else begin
        width_d[item_i.ch] = now_lo - start_q[item_i.ch];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q    <= '0;
      width_q    <= '0;
      last_act_q <= '0;
    end else begin
      start_q    <= start_d;
      width_q    <= width_d;
      last_act_q <= last_act_d;
    end
  end

  assign widths_o   = width_q;
  assign last_act_o = last_act_q;

endmodule

// ===== design/rcpcf_filter.sv =====
module rcpcf_filter #(
  parameter int FILTER_DEPTH = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         fire_i,
  input  logic [rcpcf_pkg::TIME_W-1:0] now_ms_i,
  input  rcpcf_pkg::cfg_t              cfg_i,
  input  rcpcf_pkg::chan_arr_t         widths_i,
  input  logic [rcpcf_pkg::TIME_W-1:0] last_act_i,
  output rcpcf_pkg::chan_arr_t         values_o,
  output logic                         active_o
);

  localparam int POS_W     = FILTER_DEPTH > 1 ? $clog2(FILTER_DEPTH) : 1;
  localparam int LOG_D     = $clog2(FILTER_DEPTH);
  localparam int TOT_W     = rcpcf_pkg::VAL_W + LOG_D;
  localparam int DIV_SHIFT = TOT_W + LOG_D;
  localparam int M_W       = DIV_SHIFT + 1;
  localparam int PROD_W    = TOT_W + M_W;
  localparam int ROW_W     = rcpcf_pkg::NUM_CH * rcpcf_pkg::VAL_W;
  // rounded-up reciprocal, exact floor division for any TOT_W-bit total
  localparam longint unsigned RECIP_VAL =
    ((64'd1 << DIV_SHIFT) + FILTER_DEPTH - 1) / FILTER_DEPTH;
  localparam logic [M_W-1:0]   RECIP    = M_W'(RECIP_VAL);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FILTER_DEPTH - 1);

  logic [POS_W-1:0]             pos_q, pos_d;
  logic [FILTER_DEPTH-1:0]      row_valid_q, row_valid_d;
  logic                         rd_valid_q;
  logic                         byp_q;
  logic [ROW_W-1:0]             byp_data_q;
  logic [ROW_W-1:0]             rdata;
  rcpcf_pkg::chan_arr_t         old_row;
  rcpcf_pkg::chan_arr_t         new_row;
  logic [TOT_W-1:0]             tot_q   [rcpcf_pkg::NUM_CH];
  logic [TOT_W-1:0]             tot_d   [rcpcf_pkg::NUM_CH];
  logic [TOT_W-1:0]             tot_new [rcpcf_pkg::NUM_CH];
  logic [PROD_W-1:0]            prod    [rcpcf_pkg::NUM_CH];
  rcpcf_pkg::chan_arr_t         values_q, values_d;
  logic                         flag_q, flag_d;
  logic [rcpcf_pkg::TIME_W-1:0] elapsed;
  logic                         loss;
  logic                         we;

  assign elapsed = now_ms_i - last_act_i;
  assign loss    = elapsed > {{(rcpcf_pkg::TIME_W - rcpcf_pkg::VAL_W){1'b0}}, cfg_i.timeout};
  assign we      = fire_i && !loss;

  // rows never written read as zero
  assign old_row = byp_q ? byp_data_q : (rd_valid_q ? rdata : '0);

  always_comb begin
    for (int i = 0; i < rcpcf_pkg::NUM_CH; i++) begin
      new_row[i] = (widths_i[i] != '0) ? widths_i[i] : old_row[i];
      tot_new[i] = tot_q[i] - TOT_W'(old_row[i]) + TOT_W'(new_row[i]);
      prod[i]    = PROD_W'(tot_new[i]) * PROD_W'(RECIP);
    end
  end

  always_comb begin
    pos_d       = pos_q;
    row_valid_d = row_valid_q;
    values_d    = values_q;
    flag_d      = flag_q;
    for (int i = 0; i < rcpcf_pkg::NUM_CH; i++) begin
      tot_d[i] = tot_q[i];
    end
    if (fire_i) begin
      flag_d = loss;
      if (loss) begin
        for (int i = 0; i < rcpcf_pkg::NUM_FS_CH; i++) begin
          values_d[i] = cfg_i.fs_value;
        end
      end else begin
        row_valid_d[pos_q] = 1'b1;
        pos_d = (pos_q == LAST_POS) ? '0 : pos_q + POS_W'(1);
        for (int i = 0; i < rcpcf_pkg::NUM_CH; i++) begin
          tot_d[i]    = tot_new[i];
          values_d[i] = prod[i][DIV_SHIFT +: rcpcf_pkg::VAL_W];
        end
      end
    end
  end

  // read address is the next ring position, so that row is already read out when needed
  rcpcf_ram #(
    .WIDTH (ROW_W),
    .DEPTH (FILTER_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (pos_q),
    .wdata_i (new_row),
    .raddr_i (pos_d),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      row_valid_q <= '0;
      rd_valid_q  <= 1'b0;
      byp_q       <= 1'b0;
      values_q    <= '0;
      flag_q      <= 1'b0;
      for (int i = 0; i < rcpcf_pkg::NUM_CH; i++) begin
        tot_q[i] <= '0;
      end
    end else begin
      pos_q       <= pos_d;
      row_valid_q <= row_valid_d;
      rd_valid_q  <= row_valid_q[pos_d];
      byp_q       <= we && (pos_q == pos_d);
      values_q    <= values_d;
      flag_q      <= flag_d;
      for (int i = 0; i < rcpcf_pkg::NUM_CH; i++) begin
        tot_q[i] <= tot_d[i];
      end
    end
  end

  // write-to-read forward when the same row is read right after its write
  always_ff @(posedge clk_i) begin
    byp_data_q <= new_row;
  end

  assign values_o = values_q;
  assign active_o = flag_q & cfg_i.fs_enable;

endmodule
